// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks with active-low reset gating.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// prop must hold at every rising edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// prop must never hold at a rising edge outside reset
`define ASSERT_NEVER_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER_CLK(lbl, clk, rst_n, prop, msg)

`endif

`endif

// ===== src/edtt_pkg.sv =====
// ----------------------------------------------------------------------------
// edtt_pkg
// Shared widths, constants and command codes of the earliest-deadline timer table.
// ----------------------------------------------------------------------------
package edtt_pkg;

  localparam int CMD_W          = 2;
  localparam int EVT_W          = 4;
  localparam int TIME_W         = 32;
  localparam int DELAY_W        = 31;
  localparam int DL_W           = TIME_W + 1;
  localparam int NUM_EVENTS_DEF = 16;

  localparam logic [DL_W-1:0]   FOREVER  = {1'b1, {TIME_W{1'b0}}};
  localparam logic [TIME_W-1:0] MAX_TIME = {TIME_W{1'b1}};

  typedef enum logic [CMD_W-1:0] {
    CMD_CHECK     = 2'd0,
    CMD_ARM_AT    = 2'd1,
    CMD_ARM_DELAY = 2'd2,
    CMD_DISARM    = 2'd3
  } cmd_t;

endpackage

// ===== src/edtt_if.sv =====
// ----------------------------------------------------------------------------
// edtt channel interfaces
// Valid/ready channels for timer commands and for results.
// ----------------------------------------------------------------------------
interface edtt_in_if;
  import edtt_pkg::*;

  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [EVT_W-1:0]   event_id;
  logic [TIME_W-1:0]  at_time;
  logic [TIME_W-1:0]  now_time;
  logic [DELAY_W-1:0] delay_secs;

  modport source (output valid, cmd, event_id, at_time, now_time, delay_secs, input ready);
  modport sink   (input valid, cmd, event_id, at_time, now_time, delay_secs, output ready);
endinterface

interface edtt_out_if;
  import edtt_pkg::*;

  logic             valid;
  logic             ready;
  logic [EVT_W-1:0] fired_event;
  logic [EVT_W-1:0] next_event;
  logic [DL_W-1:0]  next_deadline;

  modport source (output valid, fired_event, next_event, next_deadline, input ready);
  modport sink   (input valid, fired_event, next_event, next_deadline, output ready);
endinterface

// ===== src/edtt_ram.sv =====
// ----------------------------------------------------------------------------
// edtt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module edtt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/earliest_deadline_timer_table_unit.sv =====
// ----------------------------------------------------------------------------
// earliest_deadline_timer_table_unit
// Deadline table for event timers; tracks the earliest armed event, fires it
// on check when due, and rescans when the earliest is fired, disarmed or moved later.
// ----------------------------------------------------------------------------
//   channel   dir  handshake      payload
//   in_chan   in   valid/ready    cmd, event_id, at_time, now_time, delay_secs
//   out_chan  out  valid/ready    fired_event, next_event, next_deadline
//
// Check, arm or disarm without a rescan goes from execute straight to done.
// Rescan: one table read per cycle from the deadline RAM, entries 1 to NUM_EVENTS-1.
// Reset clears the per-entry valid bits at once; no clearing pass.
// A new item is taken while the previous result waits on out_chan; a stalled
// result holds the finished item in the done state until the output register frees.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module earliest_deadline_timer_table_unit #(
  parameter int NUM_EVENTS = edtt_pkg::NUM_EVENTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  edtt_in_if.sink           in_chan,
  edtt_out_if.source        out_chan
);
  import edtt_pkg::*;

  localparam int IDX_W = $clog2(NUM_EVENTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_EVENTS - 1);
  localparam logic [IDX_W-1:0] FIRST_IDX = IDX_W'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  state_t             state_r, state_nxt;
  cmd_t               cmd_r;
  logic [EVT_W-1:0]   evt_r;
  logic [IDX_W-1:0]   idx_r;
  logic               ok_r;
  logic [TIME_W-1:0]  at_r;
  logic [TIME_W-1:0]  now_r;
  logic [DELAY_W-1:0] dly_r;

  logic [EVT_W-1:0]      fired_r, fired_nxt;
  logic [EVT_W-1:0]      earl_evt_r, earl_evt_nxt;
  logic [DL_W-1:0]       earl_dl_r, earl_dl_nxt;
  logic [NUM_EVENTS-1:0] valid_r, valid_nxt;
  logic [IDX_W-1:0]      scan_idx_r, scan_idx_nxt;
  logic                  pend_r, pend_nxt;
  logic [IDX_W-1:0]      pend_idx_r, pend_idx_nxt;
  logic                  pend_vld_r, pend_vld_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [EVT_W-1:0] out_fired_r, out_fired_nxt;
  logic [EVT_W-1:0] out_next_evt_r, out_next_evt_nxt;
  logic [DL_W-1:0]  out_next_dl_r, out_next_dl_nxt;

  logic             in_acc;
  logic [31:0]      in_evt_ext;
  logic [DL_W-1:0]  when_sum;
  logic [DL_W-1:0]  arm_dl;
  logic             is_earl;
  logic             fire_ok;
  logic [IDX_W-1:0] fire_idx;
  logic [DL_W-1:0]  cand;

  logic              ram_wr_en;
  logic              ram_rd_en;
  logic [TIME_W-1:0] ram_rd_data;

  edtt_ram #(
    .WIDTH (TIME_W),
    .DEPTH (NUM_EVENTS)
  ) u_dl_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (idx_r),
    .wr_data (arm_dl[TIME_W-1:0]),
    .rd_en   (ram_rd_en),
    .rd_addr (scan_idx_r),
    .rd_data (ram_rd_data)
  );

  assign in_chan.ready          = (state_r == ST_IDLE);
  assign in_acc                 = in_chan.valid && in_chan.ready;
  assign in_evt_ext             = 32'(in_chan.event_id);
  assign out_chan.valid         = out_valid_r;
  assign out_chan.fired_event   = out_fired_r;
  assign out_chan.next_event    = out_next_evt_r;
  assign out_chan.next_deadline = out_next_dl_r;

  assign when_sum = {1'b0, now_r} + DL_W'(dly_r);
  assign arm_dl   = (cmd_r == CMD_ARM_AT) ? {1'b0, at_r} :
                    (when_sum[TIME_W] ? {1'b0, MAX_TIME} : when_sum);
  assign is_earl  = ok_r && (evt_r == earl_evt_r);
  assign fire_ok  = (earl_evt_r != '0) && (earl_dl_r <= {1'b0, now_r});
  assign fire_idx = IDX_W'(earl_evt_r);
  assign cand     = pend_vld_r ? {1'b0, ram_rd_data} : FOREVER;

  always_comb begin
    state_nxt        = state_r;
    fired_nxt        = fired_r;
    earl_evt_nxt     = earl_evt_r;
    earl_dl_nxt      = earl_dl_r;
    valid_nxt        = valid_r;
    scan_idx_nxt     = scan_idx_r;
    pend_nxt         = 1'b0;
    pend_idx_nxt     = pend_idx_r;
    pend_vld_nxt     = pend_vld_r;
    out_valid_nxt    = out_valid_r && !out_chan.ready;
    out_fired_nxt    = out_fired_r;
    out_next_evt_nxt = out_next_evt_r;
    out_next_dl_nxt  = out_next_dl_r;
    ram_wr_en        = 1'b0;
    ram_rd_en        = 1'b0;

    if (pend_r && (cand < earl_dl_r)) begin
      earl_evt_nxt = EVT_W'(pend_idx_r);
      earl_dl_nxt  = cand;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        fired_nxt    = '0;
        state_nxt    = ST_DONE;
        scan_idx_nxt = FIRST_IDX;
        unique case (cmd_r)
          CMD_CHECK: begin
            if (fire_ok) begin
              fired_nxt           = earl_evt_r;
              valid_nxt[fire_idx] = 1'b0;
              earl_evt_nxt        = '0;
              earl_dl_nxt         = FOREVER;
              state_nxt           = ST_SCAN;
            end
          end
          CMD_ARM_AT, CMD_ARM_DELAY: begin
            if (ok_r) begin
              ram_wr_en        = 1'b1;
              valid_nxt[idx_r] = 1'b1;
              if (arm_dl < earl_dl_r) begin
                earl_evt_nxt = evt_r;
                earl_dl_nxt  = arm_dl;
              end else if (is_earl && (arm_dl > earl_dl_r)) begin
                earl_evt_nxt = '0;
                earl_dl_nxt  = FOREVER;
                state_nxt    = ST_SCAN;
              end else if (is_earl) begin
                earl_dl_nxt = arm_dl;
              end
            end
          end
          CMD_DISARM: begin
            if (ok_r) begin
              valid_nxt[idx_r] = 1'b0;
              if (is_earl) begin
                earl_evt_nxt = '0;
                earl_dl_nxt  = FOREVER;
                state_nxt    = ST_SCAN;
              end
            end
          end
          default: begin
            state_nxt = ST_DONE;
          end
        endcase
      end
      ST_SCAN: begin
        ram_rd_en    = 1'b1;
        pend_nxt     = 1'b1;
        pend_idx_nxt = scan_idx_r;
        pend_vld_nxt = valid_r[scan_idx_r];
        if (scan_idx_r == LAST_IDX) begin
          state_nxt = ST_DRAIN;
        end else begin
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt    = 1'b1;
          out_fired_nxt    = fired_r;
          out_next_evt_nxt = earl_evt_r;
          out_next_dl_nxt  = earl_dl_r;
          state_nxt        = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      earl_evt_r  <= '0;
      earl_dl_r   <= FOREVER;
      valid_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      earl_evt_r  <= earl_evt_nxt;
      earl_dl_r   <= earl_dl_nxt;
      valid_r     <= valid_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (in_acc) begin
      cmd_r <= cmd_t'(in_chan.cmd);
      evt_r <= in_chan.event_id;
      idx_r <= in_evt_ext[IDX_W-1:0];
      ok_r  <= (in_chan.event_id != '0) && (in_evt_ext < 32'(NUM_EVENTS));
      at_r  <= in_chan.at_time;
      now_r <= in_chan.now_time;
      dly_r <= in_chan.delay_secs;
    end
    fired_r        <= fired_nxt;
    scan_idx_r     <= scan_idx_nxt;
    pend_idx_r     <= pend_idx_nxt;
    pend_vld_r     <= pend_vld_nxt;
    out_fired_r    <= out_fired_nxt;
    out_next_evt_r <= out_next_evt_nxt;
    out_next_dl_r  <= out_next_dl_nxt;
  end

  `ASSERT_CLK(a_accept_to_exec, clk, rst_n, in_acc |=> (state_r == ST_EXEC), "accepted item did not enter execute")
  `ASSERT_NEVER_CLK(a_scan_skips_null, clk, rst_n, (state_r == ST_SCAN) && (scan_idx_r == '0), "rescan read the null entry")
  `ASSERT_CLK(a_none_is_forever, clk, rst_n, ((state_r == ST_IDLE) && (earl_evt_r == '0)) |-> (earl_dl_r == FOREVER), "no earliest event but deadline set")
  `ASSERT_CLK(a_armed_not_forever, clk, rst_n, ((state_r == ST_IDLE) && (earl_evt_r != '0)) |-> !earl_dl_r[TIME_W], "earliest event carries forever")
  `ASSERT_CLK(a_result_from_done, clk, rst_n, $rose(out_valid_r) |-> ($past(state_r) == ST_DONE), "result raised outside done state")

endmodule

// ===== bench/timer_table_checker.sv =====
// ----------------------------------------------------------------------------
// timer_table_checker
// Watches the command and result channels of the timer table, keeps its own
// deadline table, earliest event and earliest deadline, and compares every
// accepted report field by field with the oldest predicted report.
// ----------------------------------------------------------------------------
module timer_table_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [edtt_pkg::CMD_W-1:0]   in_cmd,
  input  logic [edtt_pkg::EVT_W-1:0]   in_event_id,
  input  logic [edtt_pkg::TIME_W-1:0]  in_at_time,
  input  logic [edtt_pkg::TIME_W-1:0]  in_now_time,
  input  logic [edtt_pkg::DELAY_W-1:0] in_delay_secs,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [edtt_pkg::EVT_W-1:0]   out_fired_event,
  input  logic [edtt_pkg::EVT_W-1:0]   out_next_event,
  input  logic [edtt_pkg::DL_W-1:0]    out_next_deadline,
  output int                           fail_count,
  output int                           pending_reports,
  output int                           cmds_seen,
  output int                           reports_seen,
  output int                           expiries_seen
);
  import edtt_pkg::*;

  typedef struct packed {
    logic [EVT_W-1:0] fired;
    logic [EVT_W-1:0] next_ev;
    logic [DL_W-1:0]  next_dl;
  } timer_report_t;

  logic [DL_W-1:0]  deadline_tbl [NUM_EVENTS_DEF];
  logic [EVT_W-1:0] soonest_ev;
  logic [DL_W-1:0]  soonest_dl;
  timer_report_t    report_q [$];
  int               errs;
  int               n_cmds;
  int               n_reports;
  int               n_expiries;

  function automatic void rescan_table();
    soonest_ev = '0;
    soonest_dl = FOREVER;
    for (int i = 1; i < NUM_EVENTS_DEF; i++) begin
      if (deadline_tbl[i] < soonest_dl) begin
        soonest_ev = i[EVT_W-1:0];
        soonest_dl = deadline_tbl[i];
      end
    end
  endfunction

  function automatic void arm_timer(logic [EVT_W-1:0] ev, logic [DL_W-1:0] when);
    deadline_tbl[ev] = when;
    if (when < soonest_dl) begin
      soonest_ev = ev;
      soonest_dl = when;
    end else if (ev == soonest_ev && when > soonest_dl) begin
      rescan_table();
    end else if (ev == soonest_ev) begin
      soonest_dl = when;
    end
  endfunction

  function automatic void disarm_timer(logic [EVT_W-1:0] ev);
    deadline_tbl[ev] = FOREVER;
    if (ev == soonest_ev) rescan_table();
  endfunction

  function automatic timer_report_t apply_timer_cmd(cmd_t op, logic [EVT_W-1:0] ev,
                                                   logic [TIME_W-1:0] at,
                                                   logic [TIME_W-1:0] now,
                                                   logic [DELAY_W-1:0] dly);
    timer_report_t   rep;
    logic [DL_W-1:0] when;
    logic            named;
    named = (ev != '0) && (int'(ev) < NUM_EVENTS_DEF);
    rep.fired = '0;
    case (op)
      CMD_CHECK: begin
        if (soonest_dl <= {1'b0, now} && soonest_ev != '0) begin
          rep.fired = soonest_ev;
          disarm_timer(soonest_ev);
        end
      end
      CMD_ARM_AT: begin
        if (named) arm_timer(ev, {1'b0, at});
      end
      CMD_ARM_DELAY: begin
        if (named) begin
          when = {1'b0, now} + {2'b00, dly};
          if (when > {1'b0, MAX_TIME}) when = {1'b0, MAX_TIME};
          arm_timer(ev, when);
        end
      end
      CMD_DISARM: begin
        if (named) disarm_timer(ev);
      end
      default: ;
    endcase
    rep.next_ev = soonest_ev;
    rep.next_dl = soonest_dl;
    return rep;
  endfunction

  function automatic void check_field(string name, logic [DL_W-1:0] want,
                                      logic [DL_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      errs++;
    end
  endfunction

  always @(posedge clk) begin
    timer_report_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_EVENTS_DEF; i++) deadline_tbl[i] = FOREVER;
      soonest_ev = '0;
      soonest_dl = FOREVER;
      report_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        n_reports++;
        if (report_q.size() == 0) begin
          $error("unexpected report: fired_event %0d, next_event %0d, next_deadline %0d",
                 out_fired_event, out_next_event, out_next_deadline);
          errs++;
        end else begin
          want = report_q.pop_front();
          if (want.fired != '0) n_expiries++;
          check_field("fired_event", DL_W'(want.fired), DL_W'(out_fired_event));
          check_field("next_event", DL_W'(want.next_ev), DL_W'(out_next_event));
          check_field("next_deadline", want.next_dl, out_next_deadline);
        end
      end
      if (in_valid && in_ready) begin
        n_cmds++;
        report_q.push_back(apply_timer_cmd(cmd_t'(in_cmd), in_event_id, in_at_time,
                                           in_now_time, in_delay_secs));
      end
    end
    fail_count      <= errs;
    pending_reports <= report_q.size();
    cmds_seen       <= n_cmds;
    reports_seen    <= n_reports;
    expiries_seen   <= n_expiries;
  end

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives timer commands into the earliest-deadline timer table: a directed
// run over null events, ties, re-arms, saturation and expiry, then random
// commands around a moving notion of now, with random gaps and stalls on
// both channels and long result back-pressure. The checker gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import edtt_pkg::*;

  localparam int RANDOM_CMDS = 1350;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;

  logic clk;
  logic rst_n;
  int   cycle_count = 0;
  int   reports_taken = 0;
  bit   burst = 1'b0;

  int fail_count;
  int pending_reports;
  int cmds_seen;
  int reports_seen;
  int expiries_seen;

  edtt_in_if  in_if ();
  edtt_out_if out_if ();

  earliest_deadline_timer_table_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  timer_table_checker chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_if.valid),
    .in_ready          (in_if.ready),
    .in_cmd            (in_if.cmd),
    .in_event_id       (in_if.event_id),
    .in_at_time        (in_if.at_time),
    .in_now_time       (in_if.now_time),
    .in_delay_secs     (in_if.delay_secs),
    .out_valid         (out_if.valid),
    .out_ready         (out_if.ready),
    .out_fired_event   (out_if.fired_event),
    .out_next_event    (out_if.next_event),
    .out_next_deadline (out_if.next_deadline),
    .fail_count        (fail_count),
    .pending_reports   (pending_reports),
    .cmds_seen         (cmds_seen),
    .reports_seen      (reports_seen),
    .expiries_seen     (expiries_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycle_count);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic issue_cmd(input cmd_t op, input logic [EVT_W-1:0] ev,
                           input logic [TIME_W-1:0] at, input logic [TIME_W-1:0] now,
                           input logic [DELAY_W-1:0] dly);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.cmd        <= op;
    in_if.event_id   <= ev;
    in_if.at_time    <= at;
    in_if.now_time   <= now;
    in_if.delay_secs <= dly;
    do @(posedge clk); while (!(in_if.valid && in_if.ready));
  endtask

  initial begin : result_sink
    int stall;
    forever begin
      if (reports_taken == 60 || reports_taken == 800) stall = 400;
      else if (reports_taken % 150 < 30) stall = 0;
      else stall = $urandom_range(0, 17);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!(out_if.valid && out_if.ready));
      reports_taken++;
    end
  end

  initial begin : stimulus
    logic [TIME_W-1:0]  sim_now;
    logic [TIME_W-1:0]  at;
    logic [TIME_W-1:0]  now;
    logic [DELAY_W-1:0] dly;
    logic [EVT_W-1:0]   ev;
    int                 pick;

    rst_n            <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.cmd        <= '0;
    in_if.event_id   <= '0;
    in_if.at_time    <= '0;
    in_if.now_time   <= '0;
    in_if.delay_secs <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    issue_cmd(CMD_CHECK, 4'd0, '0, MAX_TIME, '0);
    issue_cmd(CMD_ARM_AT, 4'd0, 32'd5, '0, '0);
    issue_cmd(CMD_DISARM, 4'd0, '0, '0, '0);
    issue_cmd(CMD_ARM_AT, 4'd15, MAX_TIME, '0, '0);
    issue_cmd(CMD_ARM_AT, 4'd1, '0, '0, '0);
    issue_cmd(CMD_CHECK, 4'd0, '0, '0, '0);
    issue_cmd(CMD_ARM_DELAY, 4'd3, '0, MAX_TIME, {DELAY_W{1'b1}});
    issue_cmd(CMD_DISARM, 4'd15, '0, '0, '0);
    issue_cmd(CMD_ARM_DELAY, 4'd2, '0, 32'd100, '0);
    issue_cmd(CMD_ARM_AT, 4'd4, 32'd100, '0, '0);
    issue_cmd(CMD_ARM_AT, 4'd2, 32'd50, '0, '0);
    issue_cmd(CMD_ARM_AT, 4'd2, 32'd50, '0, '0);
    issue_cmd(CMD_ARM_AT, 4'd2, 32'd200, '0, '0);
    issue_cmd(CMD_DISARM, 4'd7, '0, '0, '0);
    issue_cmd(CMD_DISARM, 4'd4, '0, '0, '0);
    issue_cmd(CMD_CHECK, 4'd9, '0, 32'd199, '0);
    issue_cmd(CMD_CHECK, 4'd9, '0, 32'd200, '0);
    issue_cmd(CMD_ARM_AT, 4'd5, 32'hAAAA_AAAA, 32'h5555_5555, 31'h2AAA_AAAA);
    issue_cmd(CMD_ARM_AT, 4'd10, 32'h5555_5555, 32'hAAAA_AAAA, 31'h5555_5555);
    issue_cmd(CMD_ARM_DELAY, 4'd6, '0, 32'h5555_5555, 31'h2AAA_AAAA);
    issue_cmd(CMD_ARM_DELAY, 4'd8, '0, 32'hAAAA_AAAA, 31'h5555_5555);
    issue_cmd(CMD_CHECK, 4'd0, '0, MAX_TIME, '0);
    issue_cmd(CMD_CHECK, 4'd0, '0, MAX_TIME, '0);
    issue_cmd(CMD_CHECK, 4'd0, '0, MAX_TIME, '0);
    issue_cmd(CMD_DISARM, 4'd3, '0, '0, '0);

    sim_now = $urandom_range(1000, 100000);
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      burst = (n % 200) < 40;
      if ($urandom_range(0, 199) == 0) sim_now = $urandom;
      ev   = EVT_W'($urandom_range(0, 15));
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        now = ($urandom_range(0, 19) == 0) ? $urandom : sim_now;
        issue_cmd(CMD_CHECK, ev, $urandom, now, DELAY_W'($urandom));
        sim_now = sim_now + $urandom_range(0, 40);
      end else if (pick < 55) begin
        at = ($urandom_range(0, 9) == 0) ? $urandom : sim_now + 8 * $urandom_range(0, 25);
        issue_cmd(CMD_ARM_AT, ev, at, $urandom, DELAY_W'($urandom));
      end else if (pick < 80) begin
        now = ($urandom_range(0, 19) == 0) ? $urandom : sim_now;
        dly = ($urandom_range(0, 9) == 0) ? DELAY_W'($urandom)
                                          : DELAY_W'($urandom_range(0, 200));
        issue_cmd(CMD_ARM_DELAY, ev, $urandom, now, dly);
      end else begin
        issue_cmd(CMD_DISARM, ev, $urandom, $urandom, DELAY_W'($urandom));
      end
    end
    in_if.valid <= 1'b0;

    @(posedge clk);
    while (pending_reports != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d timer commands, checked %0d reports", cmds_seen, reports_seen);
    $display("Reports with an expired event: %0d", expiries_seen);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
